FILE: hw/rtl/tlik_pkg.sv
// Shared constants and helper functions for the two-link inverse kinematics block.
`timescale 1ns / 1ps
package tlik_pkg;

  // Number of CORDIC micro-rotations; the arctangent table holds 24 entries.
  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN    = 24;
  localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                                     CORDIC_ITERATIONS : ATAN_TABLE_LEN;

  // Vector datapath width of the CORDIC (operands below 2^36 plus gain headroom).
  localparam int VEC_W       = 38;
  // Internal angle width, 2^-24 rad per unit.
  localparam int ANG_W       = 28;
  // Normalisation brings the larger magnitude into [2^NORM_EXP, 2^(NORM_EXP+1)).
  localparam int NORM_EXP    = 34;
  localparam int NORM_STAGES = 6;
  localparam int ATAN_LAT    = NORM_STAGES + 1 + CORDIC_STEPS;

  // Square root: radicand and root widths, one result bit per stage.
  localparam int RAD_W    = 64;
  localparam int ROOT_W   = 32;
  localparam int SQRT_LAT = ROOT_W;

  // Field widths.
  localparam int COORD_W = 17;
  localparam int LINK_W  = 16;
  localparam int OUT_W   = 18;

  // Output rounding from 2^-24 rad to 2^-14 rad.
  localparam int ANG_SHIFT = 10;

  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(26353589);
  localparam logic signed [ANG_W-1:0] ANG_PI      = ANG_W'(52707179);

  // Configuration register indexes.
  localparam logic CFG_UPPER_LINK = 1'b0;
  localparam logic CFG_LOWER_LINK = 1'b1;

  // atan(2^-i) in 2^-24 rad, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_angle(input int i);
    logic signed [ANG_W-1:0] a;
    case (i)
      0:       a = ANG_W'(13176795);
      1:       a = ANG_W'(7778716);
      2:       a = ANG_W'(4110060);
      3:       a = ANG_W'(2086331);
      4:       a = ANG_W'(1047214);
      5:       a = ANG_W'(524117);
      6:       a = ANG_W'(262123);
      7:       a = ANG_W'(131069);
      default: a = ANG_W'(1) <<< (24 - i);
    endcase
    return a;
  endfunction

endpackage

FILE: hw/rtl/tlik_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
module tlik_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tlik_pkg::RAD_W-1:0]  num_in,
  output logic [tlik_pkg::ROOT_W-1:0] root
);
  import tlik_pkg::*;

  logic [RAD_W-1:0] num [0:SQRT_LAT];
  logic [RAD_W-1:0] res [0:SQRT_LAT];

  assign num[0] = num_in;
  assign res[0] = '0;

  // Each stage tries one bit of the root against the remaining radicand.
  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_step
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * i);
    logic [RAD_W-1:0] trial;

    assign trial = res[i] + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (num[i] >= trial) begin
          num[i+1] <= num[i] - trial;
          res[i+1] <= (res[i] >> 1) + BIT;
        end else begin
          num[i+1] <= num[i];
          res[i+1] <= res[i] >> 1;
        end
      end
    end
  end

  assign root = res[SQRT_LAT][ROOT_W-1:0];

endmodule

FILE: hw/rtl/tlik_atan2.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in 2^-24 rad.
`timescale 1ns / 1ps
module tlik_atan2 (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [tlik_pkg::VEC_W-1:0] y_in,
  input  logic signed [tlik_pkg::VEC_W-1:0] x_in,
  output logic signed [tlik_pkg::ANG_W-1:0] angle
);
  import tlik_pkg::*;

  logic signed [VEC_W-1:0] nx [0:NORM_STAGES];
  logic signed [VEC_W-1:0] ny [0:NORM_STAGES];
  logic                    nz [0:NORM_STAGES];
  logic signed [VEC_W-1:0] cx [0:CORDIC_STEPS];
  logic signed [VEC_W-1:0] cy [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] cz [0:CORDIC_STEPS];
  logic                    cf [0:CORDIC_STEPS];

  assign nx[0] = x_in;
  assign ny[0] = y_in;
  assign nz[0] = (x_in == '0) && (y_in == '0);

  // Normalisation: binary search for the largest left shift that keeps both
  // magnitudes below 2^(NORM_EXP+1), one shift weight per stage.
  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    localparam int SH = 1 << (NORM_STAGES - 1 - k);
    logic [VEC_W-1:0] ax, ay, orm;

    always_comb begin
      ax  = nx[k][VEC_W-1] ? VEC_W'(-nx[k]) : VEC_W'(nx[k]);
      ay  = ny[k][VEC_W-1] ? VEC_W'(-ny[k]) : VEC_W'(ny[k]);
      orm = ax | ay;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nz[k+1] <= nz[k];
        if ((orm >> (NORM_EXP + 1 - SH)) == '0) begin
          nx[k+1] <= nx[k] <<< SH;
          ny[k+1] <= ny[k] <<< SH;
        end else begin
          nx[k+1] <= nx[k];
          ny[k+1] <= ny[k];
        end
      end
    end
  end

  // Left half plane: rotate by a quarter turn and start from +/- pi/2.
  always_ff @(posedge clk) begin
    if (en) begin
      cf[0] <= nz[NORM_STAGES];
      if (nx[NORM_STAGES][VEC_W-1]) begin
        if (!ny[NORM_STAGES][VEC_W-1]) begin
          cx[0] <= ny[NORM_STAGES];
          cy[0] <= -nx[NORM_STAGES];
          cz[0] <= ANG_HALF_PI;
        end else begin
          cx[0] <= -ny[NORM_STAGES];
          cy[0] <= nx[NORM_STAGES];
          cz[0] <= -ANG_HALF_PI;
        end
      end else begin
        cx[0] <= nx[NORM_STAGES];
        cy[0] <= ny[NORM_STAGES];
        cz[0] <= '0;
      end
    end
  end

  // Micro-rotations driving y towards zero.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [ANG_W-1:0] STEP_ANG = atan_angle(i);
    logic signed [VEC_W-1:0] xs, ys;
    logic                    ypos;

    assign xs   = cx[i] >>> i;
    assign ys   = cy[i] >>> i;
    assign ypos = !cy[i][VEC_W-1] && (cy[i] != '0);

    always_ff @(posedge clk) begin
      if (en) begin
        cf[i+1] <= cf[i];
        if (ypos) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + STEP_ANG;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - STEP_ANG;
        end
      end
    end
  end

  // A null vector has angle zero.
  assign angle = cf[CORDIC_STEPS] ? '0 : cz[CORDIC_STEPS];

endmodule

FILE: hw/rtl/two_link_inverse_kinematics.sv
// Throughput: one transfer per cycle unless stalled; the depth is set by the 32-stage square root
// and the three CORDIC units (6 normalise, 1 quarter-turn, one stage per rotation).
// A skid register behind the output register lets one more result finish while m_tready is low.
// Reset (synchronous, rst high) empties the pipeline and loads link lengths 13763 and 15073.
`timescale 1ns / 1ps
module two_link_inverse_kinematics (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [16:0] target_x, [33:17] target_y, rest zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [17:0] joint_one_angle, [35:18] joint_two_angle, rest zero
  output logic        m_tuser    // [0] reachable
);
  import tlik_pkg::*;

  localparam int TOTAL_LAT = 10 + SQRT_LAT + ATAN_LAT;
  localparam int SUM_W     = ANG_W + 3;
  localparam int N_W       = 36;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [N_W-1:0]     n;
    logic signed [N_W-1:0]     m;
    logic                      bad;
    logic [2:0]                e;
  } side_t;

  function automatic logic [5:0] bit_length(input logic [33:0] v);
    logic [5:0] n;
    n = '0;
    for (int k = 0; k < 34; k++) begin
      if (v[k]) n = 6'(k + 1);
    end
    return n;
  endfunction

  // Configuration registers.
  logic [LINK_W-1:0] upper_link_length, lower_link_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= LINK_W'(13763);
      lower_link_length <= LINK_W'(15073);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UPPER_LINK: upper_link_length <= cfg_data;
        CFG_LOWER_LINK: lower_link_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline enable and valid bits; no transfer is taken while reset is held.
  logic                 en;
  logic                 skid_valid;
  logic [TOTAL_LAT-1:0] vp;

  assign en       = !skid_valid;
  assign s_tready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[TOTAL_LAT-2:0], s_tvalid};
    end
  end

  // Stage 0: input registers.
  logic signed [COORD_W-1:0] x0, y0;
  logic [LINK_W-1:0]         l1_0, l2_0;

  always_ff @(posedge clk) begin
    if (en) begin
      x0   <= s_tdata[16:0];
      y0   <= s_tdata[33:17];
      l1_0 <= upper_link_length;
      l2_0 <= lower_link_length;
    end
  end

  // Stage 1: squares.
  logic signed [2*COORD_W-1:0] xsq, ysq;
  logic signed [LINK_W:0]      ldif;
  logic [LINK_W:0]             lsum;
  logic [2*LINK_W+1:0]         ldif_sq;
  logic [32:0]                 xx1, yy1;
  logic [31:0]                 l1sq1, l2sq1, dm1;
  logic [33:0]                 sp1;
  logic                        lz1;
  logic signed [COORD_W-1:0]   x1, y1;

  always_comb begin
    xsq     = x0 * x0;
    ysq     = y0 * y0;
    ldif    = $signed({1'b0, l1_0}) - $signed({1'b0, l2_0});
    lsum    = {1'b0, l1_0} + {1'b0, l2_0};
    ldif_sq = 34'(ldif * ldif);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx1   <= xsq[32:0];
      yy1   <= ysq[32:0];
      l1sq1 <= l1_0 * l1_0;
      l2sq1 <= l2_0 * l2_0;
      dm1   <= ldif_sq[31:0];
      sp1   <= lsum * lsum;
      lz1   <= (l1_0 == '0) || (l2_0 == '0);
      x1    <= x0;
      y1    <= y0;
    end
  end

  // Stage 2: squared distance and link-square sums.
  logic [33:0]               d2_2, sp2;
  logic [32:0]               ssum2;
  logic signed [32:0]        sdif2;
  logic [31:0]               dm2;
  logic                      lz2;
  logic signed [COORD_W-1:0] x2, y2;

  always_ff @(posedge clk) begin
    if (en) begin
      d2_2  <= {1'b0, xx1} + {1'b0, yy1};
      ssum2 <= {1'b0, l1sq1} + {1'b0, l2sq1};
      sdif2 <= $signed({1'b0, l1sq1}) - $signed({1'b0, l2sq1});
      dm2   <= dm1;
      sp2   <= sp1;
      lz2   <= lz1;
      x2    <= x1;
      y2    <= y1;
    end
  end

  // Stage 3: cosine terms, radicand factors and the reach check.
  side_t       sb3;
  logic [33:0] p3, q3;

  always_ff @(posedge clk) begin
    if (en) begin
      sb3.x   <= x2;
      sb3.y   <= y2;
      sb3.n   <= $signed({3'b0, ssum2}) - $signed({2'b0, d2_2});
      sb3.m   <= N_W'(sdif2) + $signed({2'b0, d2_2});
      sb3.bad <= lz2 || (d2_2 == '0) || (d2_2 < 34'(dm2)) || (d2_2 > sp2);
      sb3.e   <= '0;
      p3      <= d2_2 - 34'(dm2);
      q3      <= sp2 - d2_2;
    end
  end

  // Stage 4: pre-shift so the product stays below 2^63.
  logic [6:0]  blsum;
  logic [6:0]  over;
  logic [2:0]  e_next;
  side_t       sb4_next;
  side_t       sb4;
  logic [33:0] p4, q4;

  always_comb begin
    blsum      = 7'(bit_length(p3)) + 7'(bit_length(q3));
    over       = (blsum > 7'd63) ? blsum - 7'd63 : 7'd0;
    e_next     = 3'((over + 7'd1) & ~7'd1);
    sb4_next   = sb3;
    sb4_next.e = e_next;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb4 <= sb4_next;
      p4  <= p3;
      q4  <= q3;
    end
  end

  // Stage 5: truncate the larger factor.
  side_t       sb5;
  logic [33:0] p5, q5;

  always_ff @(posedge clk) begin
    if (en) begin
      sb5 <= sb4;
      if (p4 >= q4) begin
        p5 <= p4 >> sb4.e;
        q5 <= q4;
      end else begin
        p5 <= p4;
        q5 <= q4 >> sb4.e;
      end
    end
  end

  // Stage 6: partial products of 17-bit halves.
  side_t       sb6;
  logic [33:0] hh6, hl6, lh6, ll6;

  always_ff @(posedge clk) begin
    if (en) begin
      sb6 <= sb5;
      hh6 <= p5[33:17] * q5[33:17];
      hl6 <= p5[33:17] * q5[16:0];
      lh6 <= p5[16:0] * q5[33:17];
      ll6 <= p5[16:0] * q5[16:0];
    end
  end

  // Stage 7: radicand.
  side_t            sb7;
  logic [RAD_W-1:0] prod7;

  always_ff @(posedge clk) begin
    if (en) begin
      sb7   <= sb6;
      prod7 <= (RAD_W'(hh6) << 34) + ((RAD_W'(hl6) + RAD_W'(lh6)) << 17) + RAD_W'(ll6);
    end
  end

  // Square root, with the side data delayed alongside.
  logic [ROOT_W-1:0] root;
  side_t             sbd [0:SQRT_LAT-1];

  tlik_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .num_in (prod7),
    .root   (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sbd[0] <= sb7;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sbd[k] <= sbd[k-1];
      end
    end
  end

  // Shared sine term, scaled back by half the pre-shift.
  logic [ROOT_W+2:0] rr;
  side_t             sbr;

  always_ff @(posedge clk) begin
    if (en) begin
      rr  <= (ROOT_W+3)'(root) << sbd[SQRT_LAT-1].e[2:1];
      sbr <= sbd[SQRT_LAT-1];
    end
  end

  // Three arctangents: elbow, base interior and target direction.
  logic signed [VEC_W-1:0] rr_v;
  logic signed [ANG_W-1:0] gamma_a, beta_a, alpha_a;
  logic                    badd [0:ATAN_LAT-1];

  assign rr_v = VEC_W'($signed({1'b0, rr}));

  tlik_atan2 u_gamma (
    .clk   (clk),
    .en    (en),
    .y_in  (rr_v),
    .x_in  (VEC_W'(sbr.n)),
    .angle (gamma_a)
  );

  tlik_atan2 u_beta (
    .clk   (clk),
    .en    (en),
    .y_in  (rr_v),
    .x_in  (VEC_W'(sbr.m)),
    .angle (beta_a)
  );

  tlik_atan2 u_alpha (
    .clk   (clk),
    .en    (en),
    .y_in  (VEC_W'(sbr.y)),
    .x_in  (VEC_W'(sbr.x)),
    .angle (alpha_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      badd[0] <= sbr.bad;
      for (int k = 1; k < ATAN_LAT; k++) begin
        badd[k] <= badd[k-1];
      end
    end
  end

  // Sum stage.
  logic signed [SUM_W-1:0] sab;
  logic signed [ANG_W-1:0] gam;
  logic                    bads;

  always_ff @(posedge clk) begin
    if (en) begin
      sab  <= SUM_W'(alpha_a) + SUM_W'(beta_a);
      gam  <= gamma_a;
      bads <= badd[ATAN_LAT-1];
    end
  end

  // Joint angles, rounded to 2^-14 rad.
  logic signed [SUM_W-1:0] t1, t2;
  logic [OUT_W-1:0]        q1, q2;
  logic [39:0]             res_data;
  logic                    res_user;

  always_comb begin
    t1 = SUM_W'(ANG_HALF_PI) + SUM_W'(512) - sab;
    t2 = SUM_W'(ANG_PI) + SUM_W'(512) - sab - SUM_W'(gam);
    q1 = t1[OUT_W+ANG_SHIFT-1:ANG_SHIFT];
    q2 = t2[OUT_W+ANG_SHIFT-1:ANG_SHIFT];
    if (bads) begin
      res_data = '0;
      res_user = 1'b0;
    end else begin
      res_data = {4'b0, q2, q1};
      res_user = 1'b1;
    end
  end

  // Output register with a skid entry behind it.
  logic [39:0] skid_data;
  logic        skid_user;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= vp[TOTAL_LAT-1];
      end else if (vp[TOTAL_LAT-1]) begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= res_data;
        m_tuser <= res_user;
      end else begin
        skid_data <= res_data;
        skid_user <= res_user;
      end
    end else if (m_tready) begin
      m_tdata <= skid_data;
      m_tuser <= skid_user;
    end
  end

  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid) else $error("skid entry full with output empty");

  // An unreachable target carries zero angles.
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0) else $error("unreachable result not zero");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid && !skid_valid && vp == '0) else $error("pipeline not empty after reset");

  // A stall freezes the valid bits.
  a_stall_holds: assert property (@(posedge clk)
    !rst && !s_tready |=> $stable(vp)) else $error("pipeline moved during a stall");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the two-link inverse kinematics block.
`timescale 1ns / 1ps
module tb_top;
  import tlik_pkg::*;

  localparam int MAX_WAIT   = 18;
  localparam int N_RANDOM   = 1800;
  localparam int LATENCY    = 80;
  localparam int IDLE_LIMIT = 20000;

  // Fixed-point angle constants, 2^-24 rad per unit.
  localparam longint HALF_PI_FINE = 64'sd26353589;
  localparam longint PI_FINE      = 64'sd52707179;

  typedef struct packed {
    logic signed [OUT_W-1:0] q1;
    logic signed [OUT_W-1:0] q2;
    logic                    reach;
  } angles_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        known;
    angles_t                   want;
  } target_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_UPPER_LINK;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  two_link_inverse_kinematics dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Link lengths as the predictor sees them.
  longint  upper_len = 13763;
  longint  lower_len = 15073;
  angles_t expected_angles[$];
  int      mismatches = 0;
  int      results_seen = 0;
  int      unreachable_seen = 0;
  int      idle_cycles = 0;
  bit      stimulus_done = 1'b0;
  bit      hold_off = 1'b0;

  longint  atan_fine[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                             131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};

  function automatic int bit_length(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned num);
    longint unsigned root, probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > num) probe >>= 2;
    while (probe != 0) begin
      if (num >= root + probe) begin
        num -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint vx, vy, ang, tmp, sx, sy;
    vx = xv;
    vy = yv;
    ang = 0;
    if (vx == 0 && vy == 0) return 0;
    while ((vx < 0 ? -vx : vx) < (64'sd1 <<< 34) && (vy < 0 ? -vy : vy) < (64'sd1 <<< 34)) begin
      vx *= 2;
      vy *= 2;
    end
    // Quarter-turn pre-rotation brings the vector into the right half-plane.
    if (vx < 0) begin
      tmp = vx;
      if (vy >= 0) begin
        vx = vy; vy = -tmp; ang = HALF_PI_FINE;
      end else begin
        vx = -vy; vy = tmp; ang = -HALF_PI_FINE;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      sx = vx >>> i;
      sy = vy >>> i;
      if (vy > 0) begin
        vx += sy; vy -= sx; ang += atan_fine[i];
      end else begin
        vx -= sy; vy += sx; ang -= atan_fine[i];
      end
    end
    return ang;
  endfunction

  function automatic logic signed [OUT_W-1:0] round_angle(longint fine);
    longint q;
    q = (fine + 512) >>> ANG_SHIFT;
    return q[OUT_W-1:0];
  endfunction

  function automatic angles_t solve_joints(logic signed [COORD_W-1:0] tx,
                                           logic signed [COORD_W-1:0] ty);
    angles_t r;
    longint x, y, d2, dm, sp, rr, alpha, beta, gamma;
    longint unsigned p, q;
    int e;
    x = tx;
    y = ty;
    r = '0;
    d2 = x * x + y * y;
    dm = (upper_len - lower_len) * (upper_len - lower_len);
    sp = (upper_len + lower_len) * (upper_len + lower_len);
    if (upper_len == 0 || lower_len == 0 || d2 == 0 || d2 < dm || d2 > sp) return r;
    p = d2 - dm;
    q = sp - d2;
    e = bit_length(p) + bit_length(q);
    e = (e > 63) ? e - 63 : 0;
    e = (e + 1) & ~1;
    if (p >= q) p >>= e;
    else q >>= e;
    rr = longint'(int_sqrt(p * q) << (e / 2));
    gamma = vector_angle(rr, upper_len * upper_len + lower_len * lower_len - d2);
    beta  = vector_angle(rr, upper_len * upper_len + d2 - lower_len * lower_len);
    alpha = vector_angle(y, x);
    r.q1 = round_angle(HALF_PI_FINE - alpha - beta);
    r.q2 = round_angle(PI_FINE - alpha - beta - gamma);
    r.reach = 1'b1;
    return r;
  endfunction

  // Register write on the falling edge, taken at the next rising edge.
  task automatic write_link(logic idx, logic [15:0] len);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_UPPER_LINK) upper_len = len;
    else lower_len = len;
  endtask

  // Offers one target and holds it until the transfer happens. The valid
  // stays high afterwards so that a following target can go back to back.
  task automatic send_target(logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty,
                             bit known, angles_t want, int gap);
    angles_t pred;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, ty, tx};
    pred = solve_joints(tx, ty);
    if (known && pred !== want)
      $display("Note: table row (%0d,%0d) differs from prediction", tx, ty);
    if (known) pred = want;
    expected_angles = {expected_angles, pred};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    return COORD_W'($urandom);
  endfunction

  // Random target: mostly inside the annulus, with some anywhere.
  task automatic random_target(output logic signed [COORD_W-1:0] tx,
                               output logic signed [COORD_W-1:0] ty);
    longint x, y, d2, dm, sp;
    int tries;
    tries = 0;
    dm = (upper_len - lower_len) * (upper_len - lower_len);
    sp = (upper_len + lower_len) * (upper_len + lower_len);
    do begin
      tx = rand_coord();
      ty = rand_coord();
      if ($urandom_range(3) == 0) begin
        tx = tx >>> $urandom_range(12);
        ty = ty >>> $urandom_range(12);
      end
      x = tx;
      y = ty;
      d2 = x * x + y * y;
      tries++;
    end while ($urandom_range(4) != 0 && (d2 < dm || d2 > sp) && tries < 50);
  endtask

  // Receiver side: random stall per result, with one long hold-off on request.
  initial begin
    int gap;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(MAX_WAIT);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    angles_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.q1 = m_tdata[17:0];
      got.q2 = m_tdata[35:18];
      got.reach = m_tuser;
      results_seen++;
      if (!got.reach) unreachable_seen++;
      if (expected_angles.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result q1=%0d q2=%0d reach=%0b",
                                       got.q1, got.q2, got.reach);
      end else begin
        want = expected_angles.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: q1 %0d/%0d q2 %0d/%0d reach %0b/%0b (expected/actual)",
                     want.q1, got.q1, want.q2, got.q2, want.reach, got.reach);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", expected_angles.size());
      $display("Verification failed");
      $finish;
    end
  end

  localparam angles_t NONE = '0;
  target_row_t directed[] = '{
    '{17'sd0, 17'sd0, 1, NONE},              // target at the origin
    '{17'sd65535, 17'sd65535, 1, NONE},      // far corner, out of reach
    '{-17'sd65536, -17'sd65536, 1, NONE},    // most negative corner
    '{17'sd100, 17'sd0, 1, NONE},            // inside the inner radius
    '{17'sd28836, 17'sd0, 0, NONE},          // fully stretched along x
    '{17'sd0, 17'sd28836, 0, NONE},          // fully stretched along y
    '{-17'sd28836, 17'sd0, 0, NONE},         // stretched, negative x
    '{17'sd0, -17'sd28836, 0, NONE},
    '{17'sd1310, 17'sd0, 0, NONE},           // folded arm
    '{17'sd20000, 17'sd5000, 0, NONE},
    '{-17'sd15000, -17'sd12000, 0, NONE},
    '{17'sd10000, -17'sd20000, 0, NONE},
    '{-17'sd65536, 17'sd65535, 1, NONE},
    '{17'sd28837, 17'sd0, 1, NONE}           // just beyond full reach
  };

  initial begin
    logic signed [COORD_W-1:0] tx, ty;
    logic [15:0] lens[5][2];
    lens = '{'{16'd1, 16'd1}, '{16'd65535, 16'd65535},
             '{16'd65535, 16'd1}, '{16'd40000, 16'd30000},
             '{16'd0, 16'd15073}};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table at reset lengths.
    foreach (directed[i])
      send_target(directed[i].x, directed[i].y, directed[i].known, directed[i].want,
                  $urandom_range(2));
    wait_drained();

    // Random phases over several link settings, the last at reset values.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 5) begin
        write_link(CFG_UPPER_LINK, lens[phase][0]);
        write_link(CFG_LOWER_LINK, lens[phase][1]);
      end else begin
        write_link(CFG_UPPER_LINK, 16'd13763);
        write_link(CFG_LOWER_LINK, 16'd15073);
      end
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        if (phase == 5 && n == 20) hold_off = 1'b1;
        random_target(tx, ty);
        send_target(tx, ty, 0, NONE,
                    (phase == 5 && n >= 20 && n < 100) ? 0 :
                    ($urandom_range(2) == 0 ? 0 : $urandom_range(MAX_WAIT)));
      end
      wait_drained();
    end

    $display("Covered %0d results (%0d unreachable) over six link-length settings,",
             results_seen, unreachable_seen);
    $display("including extreme lengths, a zero length and a long output stall.");
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d left outstanding", mismatches, expected_angles.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/tlik_pkg.sv
hw/rtl/tlik_isqrt.sv
hw/rtl/tlik_atan2.sv
hw/rtl/two_link_inverse_kinematics.sv
tb/sv/tb_top.sv
